@@ hw/rtl/lsz_pkg.sv @@
// lsz_pkg: shared types and constants for the twelve-wheel teleprinter cipher
// wheel sizes, pin-string offsets, register map and lane control struct
// no dependencies
package lsz_pkg;

  localparam int unsigned NUM_LANES     = 5;
  localparam int unsigned NUM_PIN_WORDS = 8;
  localparam int unsigned PIN_WORD_W    = 64;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned CHAR_W        = 5;
  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned WORD_SEL_W    = 3;
  // packed pin string plus one word of zero padding so every wheel window is 64 bits
  localparam int unsigned PIN_FLAT_W    = (NUM_PIN_WORDS + 1) * PIN_WORD_W;

  localparam int unsigned PSI_SIZE [NUM_LANES] = '{43, 47, 51, 53, 59};
  localparam int unsigned PSI_BASE [NUM_LANES] = '{0, 43, 90, 141, 194};
  localparam int unsigned CHI_SIZE [NUM_LANES] = '{41, 31, 29, 26, 23};
  localparam int unsigned CHI_BASE [NUM_LANES] = '{351, 392, 423, 452, 478};
  localparam int unsigned M37_SIZE = 37;
  localparam int unsigned M37_BASE = 253;
  localparam int unsigned M61_SIZE = 61;
  localparam int unsigned M61_BASE = 290;

  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [PIN_WORD_W-1:0] pin_win_t;
  typedef logic [CHAR_W-1:0]     char_t;

  // control broadcast from the top level to the wheel lanes and motor
  typedef struct packed {
    logic clear;     // reset request accepted
    logic advance;   // character accepted
    logic psi_move;  // 37-pin motor shows 1
  } step_t;

endpackage

@@ hw/rtl/lsz_lane.sv @@
// lsz_lane: one chi/psi wheel pair, gives its key bit and steps its positions
// depends on lsz_pkg
module lsz_lane (
  input  logic           clk,
  input  logic           rst,
  input  lsz_pkg::step_t step,
  input  lsz_pkg::pin_win_t chi_pins,
  input  lsz_pkg::pin_win_t psi_pins,
  input  lsz_pkg::pos_t  chi_last,
  input  lsz_pkg::pos_t  psi_last,
  output logic           key_bit
);
  import lsz_pkg::*;

  pos_t chi_pos;
  pos_t psi_pos;

  assign key_bit = chi_pins[chi_pos] ^ psi_pins[psi_pos];

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      chi_pos <= '0;
      psi_pos <= '0;
    end else if (step.advance) begin
      chi_pos <= (chi_pos == chi_last) ? '0 : chi_pos + 1'b1;
      if (step.psi_move) begin
        psi_pos <= (psi_pos == psi_last) ? '0 : psi_pos + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/lsz_motor.sv @@
// lsz_motor: the 61-pin and 37-pin motor wheels, gives the psi stepping enable
// depends on lsz_pkg
module lsz_motor (
  input  logic              clk,
  input  logic              rst,
  input  lsz_pkg::step_t    step,
  input  lsz_pkg::pin_win_t m37_pins,
  input  lsz_pkg::pin_win_t m61_pins,
  output logic              psi_move
);
  import lsz_pkg::*;

  localparam pos_t M37_LAST = POS_W'(M37_SIZE - 1);
  localparam pos_t M61_LAST = POS_W'(M61_SIZE - 1);

  pos_t m37_pos;
  pos_t m61_pos;
  logic m37_move;

  assign psi_move = m37_pins[m37_pos];
  assign m37_move = m61_pins[m61_pos];

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      m37_pos <= '0;
      m61_pos <= '0;
    end else if (step.advance) begin
      m61_pos <= (m61_pos == M61_LAST) ? '0 : m61_pos + 1'b1;
      if (m37_move) begin
        m37_pos <= (m37_pos == M37_LAST) ? '0 : m37_pos + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/twelve_wheel_teleprinter_cipher.sv @@
// twelve_wheel_teleprinter_cipher: top level, pin registers, wheel lanes, key merge, output skid
// depends on lsz_pkg, lsz_lane, lsz_motor
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------
//   input    | in_valid / in_ready         | req_type, char_bits
//   output   | out_valid / out_ready       | out_bits
//   config   | psel/penable/pwrite/pready  | paddr, pwdata, prdata (64 bit)
//
// one word per cycle while the skid entry is empty: key bits come straight from the current
// wheel positions, which update at the accepting edge, and the result is registered at that
// edge in the output register, or in the skid entry when the output is stalled
// a two-entry output (register plus skid) keeps input ready into a stall until the skid fills
// rst is synchronous: positions, pin words and valid flags all clear
// a reset request clears every position and produces no output word
module twelve_wheel_teleprinter_cipher (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [lsz_pkg::CHAR_W-1:0]  char_bits,
  // output words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lsz_pkg::CHAR_W-1:0]  out_bits,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsz_pkg::ADDR_W-1:0]  paddr,
  input  logic [lsz_pkg::PIN_WORD_W-1:0] pwdata,
  output logic [lsz_pkg::PIN_WORD_W-1:0] prdata,
  output logic                        pready
);
  import lsz_pkg::*;

  // pin words, 64-bit registers at byte offset 8*i
  logic [PIN_WORD_W-1:0] pin_word [NUM_PIN_WORDS];
  logic [WORD_SEL_W-1:0] word_sel;
  logic [PIN_FLAT_W-1:0] pin_flat;

  assign word_sel = paddr[ADDR_W-1 -: WORD_SEL_W];
  assign pready   = 1'b1;
  assign prdata   = pin_word[word_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PIN_WORDS; i++) begin
        pin_word[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      pin_word[word_sel] <= pwdata;
    end
  end

  // flatten the pin string, top word zero so wheel windows never run off the end
  always_comb begin
    pin_flat = '0;
    for (int i = 0; i < NUM_PIN_WORDS; i++) begin
      pin_flat[i*PIN_WORD_W +: PIN_WORD_W] = pin_word[i];
    end
  end

  // handshake and lane control
  logic  accept;
  logic  produce;
  step_t step;
  logic  psi_move;

  assign accept        = in_valid && in_ready;
  assign produce       = accept && (req_type == REQ_CHAR);
  assign step.clear    = accept && (req_type == REQ_RESET);
  assign step.advance  = produce;
  assign step.psi_move = psi_move;

  // motor wheels decide whether the psi wheels step
  lsz_motor u_motor (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .m37_pins (pin_flat[M37_BASE +: PIN_WORD_W]),
    .m61_pins (pin_flat[M61_BASE +: PIN_WORD_W]),
    .psi_move (psi_move)
  );

  // five lanes, one per teleprinter bit, each holding a chi and a psi wheel
  char_t key;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lsz_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .chi_pins (pin_flat[CHI_BASE[g] +: PIN_WORD_W]),
      .psi_pins (pin_flat[PSI_BASE[g] +: PIN_WORD_W]),
      .chi_last (POS_W'(CHI_SIZE[g] - 1)),
      .psi_last (POS_W'(PSI_SIZE[g] - 1)),
      .key_bit  (key[g])
    );
  end

  // merge: combine the lane key bits with the character
  char_t result;
  assign result = char_bits ^ key;

  // output register plus skid entry
  char_t skid_bits;
  logic  skid_valid;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      // output slot free or draining this cycle
      if (skid_valid) begin
        out_bits   <= skid_bits;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (produce) begin
        out_bits  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (produce) begin
      // output stalled, park the new word
      skid_bits  <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/lsz_checker.sv @@
// lsz_checker: port-level assertions for the teleprinter cipher, bound to the top level
// depends on lsz_pkg and twelve_wheel_teleprinter_cipher
module lsz_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       req_type,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lsz_pkg::CHAR_W-1:0] out_bits
);
  import lsz_pkg::*;

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an accepted character always leaves the output valid on the next cycle
  a_char_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_CHAR) |=> out_valid)
    else $error("accepted character gave no output word");

  // a reset request into an empty block gives no word
  a_reset_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_RESET && !out_valid) |=> !out_valid)
    else $error("reset request produced an output word");

  // input only backs off when a word is waiting at the output
  a_ready_backoff: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_bits)))
    else $error("stalled output word changed");

endmodule

bind twelve_wheel_teleprinter_cipher lsz_checker u_lsz_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_bits  (out_bits)
);
